// ----- sv/gibt_pkg.sv -----
`default_nettype none

package gibt_pkg;

    localparam int COORD_BITS = 13;
    localparam int LOST_BITS  = 9;
    localparam int INTER_BITS = 2 * COORD_BITS;
    localparam int UNION_BITS = 2 * COORD_BITS + 1;
    localparam int PROD_BITS  = INTER_BITS + UNION_BITS;

    localparam logic [LOST_BITS-1:0]  LOST_MAX = '1;
    localparam logic [UNION_BITS-1:0] IOU_ONE  = UNION_BITS'(65536);

    localparam logic [1:0] OP_EPOCH = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DET   = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MAX_LOST  = 2'd1;
    localparam logic [1:0] REG_MAX_TRK   = 2'd2;

    typedef struct packed {
        logic [1:0]            opcode;
        logic                  source_gap;
        logic [7:0]            detection_count;
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-1:0] box_w;
        logic [COORD_BITS-1:0] box_h;
        logic [63:0]           epoch;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] track_id;
        logic        new_track;
        logic [6:0]  live_tracks;
    } res_item_t;

    typedef struct packed {
        logic [15:0] iou_threshold;
        logic [7:0]  max_lost_frames;
        logic [6:0]  max_tracks;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-1:0] box_w;
        logic [COORD_BITS-1:0] box_h;
        logic [31:0]           ident;
        logic [LOST_BITS-1:0]  lost;
    } entry_t;

    typedef struct packed {
        logic       load;
        logic       epoch_clr;
        logic       start_apply;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd;
        logic       pass_fe;
        logic       pass_wr;
        logic       fe_finish;
        logic       best_upd;
        logic       wr_match;
        logic       wr_new;
        logic       set_fault;
        logic       finish;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       epoch_zero;
        logic       faulted;
        logic       cfg_bad;
        logic       count_over;
        logic       gap;
        logic       idx_end;
        logic       idx_masked;
        logic       best_found;
        logic       table_full;
    } sts_t;

endpackage

`default_nettype wire

// ----- sv/greedy_iou_box_tracker.sv -----
// epoch, rejected and plain frame-start items pass from start through decide and done only
// detection: one table read and a five-step overlap/ratio pipeline per unmatched live track,
// a skip per matched one; gap frame start and frame end: a table read and a write per live track
// throughput: one item at a time, next item may start in the cycle its done strobe shows
// reset (rst_n low, async): table empty, ids restart at one, registers at defaults, no sweep
// the receiver cannot stall: done is high for exactly one cycle; result holds to the next done
`default_nettype none

module greedy_iou_box_tracker
    import gibt_pkg::*;
#(
    parameter int MAX_TRACKS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        start,
    output logic             busy,
    input  wire in_item_t    item,
    // result channel
    output logic             done,
    output res_item_t        result,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    // register writes complete in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.iou_threshold   <= 16'd19661;
            cfg_reg.max_lost_frames <= 8'd30;
            cfg_reg.max_tracks      <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_THRESHOLD: cfg_reg.iou_threshold   <= pwdata[15:0];
                REG_MAX_LOST:  cfg_reg.max_lost_frames <= pwdata[7:0];
                REG_MAX_TRK:   cfg_reg.max_tracks      <= pwdata[6:0];
                default:       ;
            endcase
        end
    end

    // read-back of the register file
    always_comb
    begin
        case (paddr[3:2])
            REG_THRESHOLD: prdata = {16'd0, cfg_reg.iou_threshold};
            REG_MAX_LOST:  prdata = {24'd0, cfg_reg.max_lost_frames};
            REG_MAX_TRK:   prdata = {25'd0, cfg_reg.max_tracks};
            default:       prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // sequencer: decides the item kind and steps through table passes
    gibt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // track table, overlap pipeline and result register
    gibt_datapath #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg_reg),
        .cmd    (cmd),
        .sts    (sts),
        .result (result),
        .done   (done)
    );

endmodule

`default_nettype wire

// ----- sv/gibt_ram.sv -----
`default_nettype none

module gibt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/gibt_datapath.sv -----
`default_nettype none

module gibt_datapath
    import gibt_pkg::*;
#(
    parameter int MAX_TRACKS = 64
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  item,
    input  wire cfg_t      cfg,
    input  wire cmd_t      cmd,
    output sts_t           sts,
    output res_item_t      result,
    output logic           done
);

    localparam int LIVE_W = $clog2(MAX_TRACKS + 1);
    localparam int IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CW     = (LIVE_W > 8) ? LIVE_W : 8;

    // control state
    logic [LIVE_W-1:0]     idx_reg, wptr_reg, live_reg;
    logic [31:0]           next_id_reg;
    logic                  gap_reg, fault_reg, best_found_reg, done_reg;
    logic [MAX_TRACKS-1:0] mask_reg;

    // payload
    in_item_t              in_reg;
    res_item_t             res_reg;
    logic [31:0]           res_id_reg;
    logic                  res_new_reg;
    logic [INTER_BITS-1:0] best_i_reg;
    logic [UNION_BITS-1:0] best_u_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [31:0]           best_ident_reg;

    // overlap pipeline
    logic [COORD_BITS-1:0] s1_dx_reg, s1_dy_reg;
    logic [INTER_BITS-1:0] s1_tarea_reg, s1_darea_reg;
    logic                  s1_ok_reg, s2_ok_reg, s3_ok_reg, s4_ok_reg;
    logic [INTER_BITS-1:0] s2_inter_reg, s3_inter_reg, s4_inter_reg;
    logic [UNION_BITS-1:0] s2_sum_reg, s3_uni_reg, s4_uni_reg;
    logic [PROD_BITS-1:0]  p1_reg, p2_reg;

    entry_t                rd_ent, wr_ent;
    logic                  ram_we;
    logic [IDX_W-1:0]      waddr;
    logic [IDX_W-1:0]      cur_idx;
    logic                  age_en, keep;
    logic [LOST_BITS-1:0]  lost_next;

    logic [COORD_BITS:0]   d_x2, d_y2, t_x2, t_y2, x1, y1, x2, y2;
    logic                  nz;

    assign cur_idx = idx_reg[IDX_W-1:0];

    gibt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_TRACKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wr_ent),
        .re    (cmd.rd),
        .raddr (cur_idx),
        .rdata (rd_ent)
    );

    // aging and survival of the entry under the pass
    always_comb
    begin
        age_en    = cmd.pass_fe ? (!mask_reg[cur_idx] && !gap_reg) : 1'b1;
        lost_next = (age_en && rd_ent.lost != LOST_MAX) ? rd_ent.lost + 1'b1 : rd_ent.lost;
        keep      = cmd.pass_fe ? (lost_next <= {1'b0, cfg.max_lost_frames}) : 1'b1;
    end

    always_comb
    begin
        ram_we       = 1'b0;
        waddr        = wptr_reg[IDX_W-1:0];
        wr_ent       = rd_ent;
        wr_ent.lost  = lost_next;
        if (cmd.pass_wr)
        begin
            ram_we = keep;
        end
        else if (cmd.wr_match || cmd.wr_new)
        begin
            ram_we       = 1'b1;
            waddr        = cmd.wr_match ? best_idx_reg : live_reg[IDX_W-1:0];
            wr_ent.box_x = in_reg.box_x;
            wr_ent.box_y = in_reg.box_y;
            wr_ent.box_w = in_reg.box_w;
            wr_ent.box_h = in_reg.box_h;
            wr_ent.ident = cmd.wr_match ? best_ident_reg : next_id_reg;
            wr_ent.lost  = '0;
        end
    end

    // overlap geometry of detection against the entry just read
    always_comb
    begin
        d_x2 = {1'b0, in_reg.box_x} + {1'b0, in_reg.box_w};
        d_y2 = {1'b0, in_reg.box_y} + {1'b0, in_reg.box_h};
        t_x2 = {1'b0, rd_ent.box_x} + {1'b0, rd_ent.box_w};
        t_y2 = {1'b0, rd_ent.box_y} + {1'b0, rd_ent.box_h};
        x1   = (in_reg.box_x > rd_ent.box_x) ? {1'b0, in_reg.box_x} : {1'b0, rd_ent.box_x};
        y1   = (in_reg.box_y > rd_ent.box_y) ? {1'b0, in_reg.box_y} : {1'b0, rd_ent.box_y};
        x2   = (d_x2 < t_x2) ? d_x2 : t_x2;
        y2   = (d_y2 < t_y2) ? d_y2 : t_y2;
        nz   = (|in_reg.box_w) && (|in_reg.box_h) && (|rd_ent.box_w) && (|rd_ent.box_h);
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg    <= COORD_BITS'(x2 - x1);
        s1_dy_reg    <= COORD_BITS'(y2 - y1);
        s1_ok_reg    <= nz && (x2 > x1) && (y2 > y1);
        s1_tarea_reg <= INTER_BITS'(rd_ent.box_w) * INTER_BITS'(rd_ent.box_h);
        s1_darea_reg <= INTER_BITS'(in_reg.box_w) * INTER_BITS'(in_reg.box_h);

        s2_inter_reg <= INTER_BITS'(s1_dx_reg) * INTER_BITS'(s1_dy_reg);
        s2_sum_reg   <= UNION_BITS'(s1_tarea_reg) + UNION_BITS'(s1_darea_reg);
        s2_ok_reg    <= s1_ok_reg;

        s3_uni_reg   <= s2_sum_reg - UNION_BITS'(s2_inter_reg);
        s3_inter_reg <= s2_inter_reg;
        s3_ok_reg    <= s2_ok_reg;

        p1_reg       <= PROD_BITS'(s3_inter_reg) * PROD_BITS'(best_u_reg);
        p2_reg       <= PROD_BITS'(best_i_reg) * PROD_BITS'(s3_uni_reg);
        s4_inter_reg <= s3_inter_reg;
        s4_uni_reg   <= s3_uni_reg;
        s4_ok_reg    <= s3_ok_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= item;
        end
        if (cmd.idx_clr)
        begin
            best_i_reg <= INTER_BITS'(cfg.iou_threshold);
            best_u_reg <= IOU_ONE;
        end
        else if (cmd.best_upd && s4_ok_reg && p1_reg > p2_reg)
        begin
            best_i_reg     <= s4_inter_reg;
            best_u_reg     <= s4_uni_reg;
            best_idx_reg   <= cur_idx;
            best_ident_reg <= rd_ent.ident;
        end
        if (cmd.load)
        begin
            res_id_reg  <= '0;
            res_new_reg <= 1'b0;
        end
        else if (cmd.wr_match)
        begin
            res_id_reg <= best_ident_reg;
        end
        else if (cmd.wr_new)
        begin
            res_id_reg  <= next_id_reg;
            res_new_reg <= 1'b1;
        end
        if (cmd.finish)
        begin
            res_reg.status      <= cmd.status;
            res_reg.track_id    <= res_id_reg;
            res_reg.new_track   <= res_new_reg;
            res_reg.live_tracks <= 7'(live_reg);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            wptr_reg       <= '0;
            live_reg       <= '0;
            next_id_reg    <= 32'd1;
            gap_reg        <= 1'b0;
            fault_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            mask_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.idx_clr)
            begin
                idx_reg        <= '0;
                wptr_reg       <= '0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cmd.pass_wr && keep)
                begin
                    wptr_reg <= wptr_reg + 1'b1;
                end
                if (cmd.best_upd && s4_ok_reg && p1_reg > p2_reg)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.epoch_clr)
            begin
                live_reg    <= '0;
                next_id_reg <= 32'd1;
                mask_reg    <= '0;
                gap_reg     <= 1'b0;
                fault_reg   <= 1'b0;
            end
            if (cmd.start_apply)
            begin
                mask_reg <= '0;
                gap_reg  <= in_reg.source_gap;
            end
            if (cmd.fe_finish)
            begin
                live_reg <= wptr_reg;
                mask_reg <= '0;
            end
            if (cmd.set_fault)
            begin
                fault_reg <= 1'b1;
            end
            if (cmd.wr_match)
            begin
                mask_reg[best_idx_reg] <= 1'b1;
            end
            if (cmd.wr_new)
            begin
                mask_reg[live_reg[IDX_W-1:0]] <= 1'b1;
                live_reg    <= live_reg + 1'b1;
                next_id_reg <= next_id_reg + 32'd1;
            end
        end
    end

    always_comb
    begin
        sts.op         = in_reg.opcode;
        sts.epoch_zero = (in_reg.epoch == 64'd0);
        sts.faulted    = fault_reg;
        sts.cfg_bad    = (cfg.max_lost_frames == 8'd0) || (cfg.max_tracks == 7'd0)
                         || (CW'(cfg.max_tracks) > CW'(MAX_TRACKS));
        sts.count_over = in_reg.detection_count > 8'(cfg.max_tracks);
        sts.gap        = in_reg.source_gap;
        sts.idx_end    = idx_reg >= live_reg;
        sts.idx_masked = mask_reg[cur_idx];
        sts.best_found = best_found_reg;
        sts.table_full = (CW'(live_reg) >= CW'(cfg.max_tracks))
                         || (CW'(live_reg) >= CW'(MAX_TRACKS));
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// ----- sv/gibt_ctrl.sv -----
`default_nettype none

module gibt_ctrl
    import gibt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire sts_t sts,
    output logic      busy,
    output cmd_t      cmd
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_DECIDE  = 12'b0000_0000_0010,
        S_P_RD    = 12'b0000_0000_0100,
        S_P_WR    = 12'b0000_0000_1000,
        S_SC_RD   = 12'b0000_0001_0000,
        S_SC_OVL  = 12'b0000_0010_0000,
        S_SC_MUL  = 12'b0000_0100_0000,
        S_SC_UNI  = 12'b0000_1000_0000,
        S_SC_PROD = 12'b0001_0000_0000,
        S_SC_CMP  = 12'b0010_0000_0000,
        S_COMMIT  = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] st_reg, st_next;
    logic       fe_reg, fe_next;

    always_comb
    begin
        state_next  = state_reg;
        st_next     = st_reg;
        fe_next     = fe_reg;
        cmd         = '0;
        cmd.pass_fe = fe_reg;
        cmd.status  = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    st_next    = ST_OK;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next  = S_DONE;
                cmd.idx_clr = 1'b1;
                if (sts.op == OP_EPOCH)
                begin
                    if (sts.epoch_zero)
                    begin
                        st_next = ST_INVALID;
                    end
                    else
                    begin
                        cmd.epoch_clr = 1'b1;
                    end
                end
                else if (sts.faulted)
                begin
                    st_next = ST_EXHAUSTED;
                end
                else if (sts.cfg_bad)
                begin
                    st_next = ST_INVALID;
                end
                else if (sts.op == OP_START)
                begin
                    if (sts.count_over)
                    begin
                        st_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        cmd.start_apply = 1'b1;
                        fe_next         = 1'b0;
                        if (sts.gap)
                        begin
                            state_next = S_P_RD;
                        end
                    end
                end
                else if (sts.op == OP_DET)
                begin
                    state_next = S_SC_RD;
                end
                else
                begin
                    fe_next    = 1'b1;
                    state_next = S_P_RD;
                end
            end
            S_P_RD:
            begin
                if (sts.idx_end)
                begin
                    cmd.fe_finish = fe_reg;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_P_WR;
                end
            end
            S_P_WR:
            begin
                cmd.pass_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_P_RD;
            end
            S_SC_RD:
            begin
                if (sts.idx_end)
                begin
                    state_next = S_COMMIT;
                end
                else if (sts.idx_masked)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_SC_OVL;
                end
            end
            S_SC_OVL:  state_next = S_SC_MUL;
            S_SC_MUL:  state_next = S_SC_UNI;
            S_SC_UNI:  state_next = S_SC_PROD;
            S_SC_PROD: state_next = S_SC_CMP;
            S_SC_CMP:
            begin
                cmd.best_upd = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SC_RD;
            end
            S_COMMIT:
            begin
                if (sts.best_found)
                begin
                    cmd.wr_match = 1'b1;
                end
                else if (sts.table_full)
                begin
                    cmd.set_fault = 1'b1;
                    st_next       = ST_EXHAUSTED;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            fe_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            fe_reg    <= fe_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire
